[rtl/core/fifo_page_replacement_core_macros.svh]
`ifndef FIFO_PAGE_REPLACEMENT_CORE_MACROS_SVH
`define FIFO_PAGE_REPLACEMENT_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define FPR_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define FPR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fpr_pkg.sv]
package fpr_pkg;

    // Default sizing
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    // Fixed field widths
    localparam int CFG_W      = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int TOTAL_W    = 32;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = CFG_W'(3);

    // Control from the sequencer to the frame store
    typedef struct packed {
        logic clear;   // drop all valid bits
        logic wr_en;   // load a page into a frame
    } t_store_ctl;

endpackage

[rtl/core/fpr_frame_store.sv]
module fpr_frame_store #(
    parameter int FRAMES    = fpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF,
    parameter int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fpr_pkg::t_store_ctl   i_ctl,
    input  logic [SLOT_W-1:0]     i_rd_addr,
    input  logic [SLOT_W-1:0]     i_wr_addr,
    input  logic [PAGE_BITS-1:0]  i_wr_page,
    input  logic [PAGE_BITS-1:0]  i_cmp_page,
    output logic                  o_match
);
    import fpr_pkg::*;

    logic [PAGE_BITS-1:0] r_mem [FRAMES];
    logic [FRAMES-1:0]    r_valid;
    logic [PAGE_BITS-1:0] r_rd_page;
    logic                 r_rd_valid;
    logic                 n_rd_valid;

    // Forward a clear or a same-entry load into the registered valid read
    always_comb begin
        priority if (i_ctl.clear) begin
            n_rd_valid = 1'b0;
        end else if (i_ctl.wr_en && (i_wr_addr == i_rd_addr)) begin
            n_rd_valid = 1'b1;
        end else begin
            n_rd_valid = r_valid[i_rd_addr];
        end
    end

    // Page memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_page;
        end
        r_rd_page <= r_mem[i_rd_addr];
    end

    // Valid bits per frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_valid <= '0;
            end else if (i_ctl.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= n_rd_valid;
        end
    end

    // Match the frame read last cycle
    assign o_match = r_rd_valid && (r_rd_page == i_cmp_page);

endmodule

[rtl/core/fifo_page_replacement_core.sv]
// FIFO page replacement core.
// Input channel: i_in_valid with i_page and i_restart; the core holds o_in_stall
// high while it works on an item. Output channel: o_out_valid with o_fault,
// o_slot and o_fault_total; the receiver holds i_out_stall to keep the item.
// Configuration: i_cfg_we writes i_cfg_data into the frame count register
// (reset value 3); write it only while no item is in flight.
// Each item walks the page frame memory from frame 0, one frame per cycle until
// its lookup ends, since the frames live in a synchronous RAM with one write
// port and a registered read. A lookup ends at the first frame that hits, or on
// a miss at the last active frame. The core returns to idle when the result is
// registered, and takes no new item before then.
// A restart flag on an item clears the valid bits, the round-robin pointer
// and the fault counter before the lookup. Reset clears the same state and
// sets the frame count to 3.
// When the receiver stalls, the finished result waits in the output register;
// the next item may still be accepted and scanned, and its scan holds on the
// frame where it ends until the output register frees up.
module fifo_page_replacement_core #(
    parameter int FRAMES    = fpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [fpr_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [PAGE_BITS-1:0]           i_page,
    input  logic                           i_restart,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_fault,
    output logic [fpr_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic [fpr_pkg::TOTAL_W-1:0]    o_fault_total
);
    import fpr_pkg::*;

    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_frame_count;
    logic [CNT_W-1:0]     r_eff_n;
    logic [SLOT_W-1:0]    r_idx;
    logic [PAGE_BITS-1:0] r_page;
    logic [SLOT_W-1:0]    r_next_slot;
    logic [TOTAL_W-1:0]   r_fault_count;
    logic                 r_out_valid;
    logic                 r_fault;
    logic [SLOT_W-1:0]    r_slot;
    logic [TOTAL_W-1:0]   r_total;

    logic [CNT_W-1:0]     n_eff_n;
    logic [SLOT_W-1:0]    n_next_slot;
    logic [TOTAL_W-1:0]   n_fault_count;
    logic                 in_acc;
    logic                 hit;
    logic [CNT_W-1:0]     idx_inc;
    logic                 is_last;
    logic                 done;
    logic                 out_free;
    logic                 finish;
    logic [SLOT_W-1:0]    fill_slot;
    logic [CNT_W-1:0]     fill_inc;
    logic [SLOT_W-1:0]    rd_addr;
    t_store_ctl           st_ctl;

    // Clamp the configured frame count into 1..FRAMES
    always_comb begin
        priority if (r_frame_count == '0) begin
            n_eff_n = CNT_W'(1);
        end else if (32'(r_frame_count) > 32'(FRAMES)) begin
            n_eff_n = CNT_W'(FRAMES);
        end else begin
            n_eff_n = CNT_W'(r_frame_count);
        end
    end

    // Scan progress and handshakes
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign idx_inc  = CNT_W'(r_idx) + CNT_W'(1);
    assign is_last  = (idx_inc >= r_eff_n);
    assign done     = (r_state == S_SCAN) && (hit || is_last);
    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = done && out_free;

    // Pick the victim frame and the pointer after it
    assign fill_slot   = (CNT_W'(r_next_slot) < r_eff_n) ? r_next_slot : '0;
    assign fill_inc    = CNT_W'(fill_slot) + CNT_W'(1);
    assign n_next_slot = (fill_inc >= r_eff_n) ? '0 : SLOT_W'(fill_inc);
    assign n_fault_count = (r_fault_count == '1) ? r_fault_count
                                                 : r_fault_count + TOTAL_W'(1);

    // Read frame 0 in idle, else the next frame, or the current one while blocked
    always_comb begin
        unique case (r_state)
            S_IDLE: rd_addr = '0;
            S_SCAN: rd_addr = (done && !out_free) ? r_idx : SLOT_W'(idx_inc);
        endcase
    end

    assign st_ctl.clear = in_acc && i_restart;
    assign st_ctl.wr_en = finish && !hit;

    fpr_frame_store #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .SLOT_W    (SLOT_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (st_ctl),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (fill_slot),
        .i_wr_page  (r_page),
        .i_cmp_page (r_page),
        .o_match    (hit)
    );

    // Sequencer, run state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_count <= FRAME_COUNT_RST;
            r_eff_n       <= CNT_W'(1);
            r_next_slot   <= '0;
            r_fault_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && !finish) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_page  <= i_page;
                        r_eff_n <= n_eff_n;
                        r_idx   <= '0;
                        if (i_restart) begin
                            r_next_slot   <= '0;
                            r_fault_count <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (finish) begin
                        r_out_valid <= 1'b1;
                        r_fault     <= !hit;
                        if (hit) begin
                            r_slot  <= r_idx;
                            r_total <= r_fault_count;
                        end else begin
                            r_slot        <= fill_slot;
                            r_total       <= n_fault_count;
                            r_next_slot   <= n_next_slot;
                            r_fault_count <= n_fault_count;
                        end
                        r_state <= S_IDLE;
                    end else if (!done) begin
                        r_idx <= SLOT_W'(idx_inc);
                    end
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_fault       = r_fault;
    assign o_slot        = SLOT_OUT_W'(r_slot);
    assign o_fault_total = r_total;

`include "fifo_page_replacement_core_macros.svh"

    `FPR_ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, in_acc,
        (r_state == S_SCAN) && (r_idx == '0), "accepted item did not start at frame 0")
    `FPR_ASSERT_SAME(a_scan_in_range, i_clk, i_rst_n, r_state == S_SCAN,
        CNT_W'(r_idx) < r_eff_n, "scan index beyond active frame count")
    `FPR_ASSERT_SAME(a_fault_counted, i_clk, i_rst_n, o_out_valid && o_fault,
        o_fault_total != '0, "fault reported with zero fault total")

endmodule
